[rtl/lrp_pkg.sv]
// Package for the LED ring pixel color unit.
// Holds pattern codes, item and context types, constants and the gamma table.
// No dependencies.
package lrp_pkg;

  localparam int LRP_TIME_DIVISOR = 8;
  localparam int LRP_QUEUE_DEPTH  = 2;

  // Divider geometry for the pipelined dividers in the back end
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  localparam int CH_NW  = 24;

  localparam int                PCT_FULL   = 100;
  localparam logic [7:0]        CH_MAX     = 8'd255;
  localparam logic [7:0]        WHEEL_SEG1 = 8'd85;
  localparam logic [7:0]        WHEEL_SEG2 = 8'd170;

  typedef enum logic [2:0] {
    PAT_SOLID    = 3'd0,
    PAT_PULSE    = 3'd1,
    PAT_PROGRESS = 3'd2,
    PAT_SPIN     = 3'd3,
    PAT_RAINBOW  = 3'd4
  } lrp_pat_t;

  // Classified request as it leaves the front end
  typedef struct packed {
    logic [2:0]  pattern;
    logic [23:0] color;
    logic [15:0] period;
    logic [7:0]  pix;
    logic [7:0]  k;
    logic [7:0]  len;
    logic [15:0] fill_num;
    logic [31:0] time_ms;
  } lrp_item_t;

  // Per-request context carried through the back end dividers
  typedef struct packed {
    logic [2:0]  pattern;
    logic [23:0] color;
    logic [7:0]  pix;
    logic [31:0] t;
    logic [15:0] p;
    logic        infill;
  } lrp_ctx_t;

  typedef logic [7:0] gamma_lut_t [256];

  // Build floor(255 * (v/255)^2.5) by a bitwise search at elaboration
  function automatic gamma_lut_t gamma_build();
    gamma_lut_t      lut;
    longint unsigned v5;
    longint unsigned t;
    logic [7:0]      g;
    for (int v = 0; v < 256; v++) begin
      v5 = longint'(v) * v * v * v * v;
      g  = 8'd0;
      for (int b = 7; b >= 0; b--) begin
        t = longint'(g | (8'd1 << b));
        if (t * t * 64'd16581375 <= v5) g = 8'(t);
      end
      lut[v] = g;
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = gamma_build();

endpackage

[rtl/lrp_if.sv]
// Valid/ready channel interfaces of the LED ring pixel color unit.
// Depends on nothing; payload fields match the request and result items.
interface lrp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pattern;
  logic [23:0] ring_color;
  logic [15:0] period_ms;
  logic [7:0]  progress_percent;
  logic [7:0]  pixel_index;
  logic [7:0]  ring_start;
  logic [7:0]  ring_length;
  logic [31:0] time_ms;

  modport source(output valid, pattern, ring_color, period_ms, progress_percent,
                 pixel_index, ring_start, ring_length, time_ms, input ready);
  modport sink(input valid, pattern, ring_color, period_ms, progress_percent,
               pixel_index, ring_start, ring_length, time_ms, output ready);
endinterface

interface lrp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;

  modport source(output valid, pixel_color, input ready);
  modport sink(input valid, pixel_color, output ready);
endinterface

[rtl/lrp_front.sv]
// Front end: accepts pixel requests and classifies them into queue items.
// Depends on lrp_pkg and lrp_in_if.
module lrp_front (
  input  logic                clk,
  input  logic                rst_n,
  lrp_in_if.sink              in_if,
  input  logic                q_full,
  output logic                q_push,
  output lrp_pkg::lrp_item_t  q_item
);
  import lrp_pkg::*;

  logic      fv_r;
  logic      fv_nxt;
  lrp_item_t fitem_r;
  lrp_item_t fitem_nxt;
  logic      acc;

  assign q_push      = fv_r && !q_full;
  assign in_if.ready = !fv_r || !q_full;
  assign acc         = in_if.valid && in_if.ready;
  assign q_item      = fitem_r;

  // Classify: ring offset, safe length, fill numerator
  always_comb begin
    fitem_nxt.pattern  = in_if.pattern;
    fitem_nxt.color    = in_if.ring_color;
    fitem_nxt.period   = in_if.period_ms;
    fitem_nxt.pix      = in_if.pixel_index;
    fitem_nxt.k        = in_if.pixel_index - in_if.ring_start;
    fitem_nxt.len      = (in_if.ring_length == 8'd0) ? 8'd1 : in_if.ring_length;
    fitem_nxt.fill_num = in_if.ring_length * in_if.progress_percent;
    fitem_nxt.time_ms  = in_if.time_ms;
  end

  // Hold the stage until the queue takes it
  always_comb begin
    fv_nxt = fv_r;
    if (acc) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fitem_r <= fitem_nxt;
    end
  end

endmodule

[rtl/lrp_fifo.sv]
// Short request queue between the front end and the back end.
// Depends on lrp_pkg for the item type.
module lrp_fifo #(
  parameter int DEPTH = lrp_pkg::LRP_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lrp_pkg::lrp_item_t  din,
  input  logic                pop,
  output lrp_pkg::lrp_item_t  dout,
  output logic                full,
  output logic                empty
);
  import lrp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lrp_item_t     mem [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wp_nxt;
  logic [PW-1:0] rp_nxt;
  logic [CW-1:0] cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rp_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

endmodule

[rtl/lrp_div.sv]
// Pipelined dividers with sideband: a restoring divider with one quotient bit
// per stage, and a divider by a constant through reciprocal multiplication
// with registered partial products. Depends on nothing; used by the back end.
module lrp_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          v_r    [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] acc_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stg
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] acc_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          qbit;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_head
      assign v_in    = v_i;
      assign rem_in  = '0;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign acc_in  = acc_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial   = {rem_in, acc_in[NW-1]};
    assign qbit    = (trial >= {1'b0, den_in});
    assign rem_nxt = qbit ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        acc_r[i]  <= {acc_in[NW-2:0], qbit};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign v_o    = v_r[NW-1];
  assign quo_o  = acc_r[NW-1];
  assign rem_o  = rem_r[NW-1];
  assign side_o = side_r[NW-1];

endmodule

// Quotient by a constant: floor(n * M / 2^SH) with M = ceil(2^SH / DIVISOR)
// and SH = NW + ceil(log2(DIVISOR)), exact for every NW-bit numerator.
// The two half-width partial products are registered, then summed and shifted.
module lrp_cdiv #(
  parameter int NW      = 32,
  parameter int DIVISOR = 8,
  parameter int SW      = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int HW = NW / 2;
  localparam int MW = NW + 1;
  localparam int PW = HW + MW;
  localparam int SH = NW + $clog2(DIVISOR);
  localparam longint unsigned POW2 = 64'd1 << SH;
  localparam logic [MW-1:0] MULT =
    MW'((POW2 + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic             v1_r;
  logic             v2_r;
  logic [PW-1:0]    lo_r;
  logic [PW-1:0]    hi_r;
  logic [PW-1:0]    lo_nxt;
  logic [PW-1:0]    hi_nxt;
  logic [SW-1:0]    side1_r;
  logic [SW-1:0]    side2_r;
  logic [NW-1:0]    quo_r;
  logic [NW-1:0]    quo_nxt;
  logic [NW+MW-1:0] sum;

  // Partial products of the low and high numerator halves
  assign lo_nxt = {{MW{1'b0}}, num_i[HW-1:0]} * {{HW{1'b0}}, MULT};
  assign hi_nxt = {{MW{1'b0}}, num_i[NW-1:HW]} * {{HW{1'b0}}, MULT};

  // Recombine and drop the fraction bits
  assign sum     = {hi_r, {HW{1'b0}}} + {{HW{1'b0}}, lo_r};
  assign quo_nxt = NW'(sum >> SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      side1_r <= side_i;
      quo_r   <= quo_nxt;
      side2_r <= side1_r;
    end
  end

  assign v_o    = v2_r;
  assign quo_o  = quo_r;
  assign side_o = side2_r;

endmodule

[rtl/lrp_back.sv]
// Back end: condenses time, computes solid/pulse/progress/spin/rainbow colors and
// applies gamma. Depends on lrp_pkg, lrp_div, lrp_cdiv and lrp_out_if.
module lrp_back #(
  parameter int TIME_DIVISOR = lrp_pkg::LRP_TIME_DIVISOR
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrp_pkg::lrp_item_t  q_item,
  input  logic                q_empty,
  output logic                q_pop,
  lrp_out_if.source           out_if
);
  import lrp_pkg::*;

  localparam int CTX_W  = $bits(lrp_ctx_t);
  localparam int ITEM_W = $bits(lrp_item_t);

  logic en;

  // Constant dividers on the queue head
  logic              ct_v;
  logic [DIV_NW-1:0] ct_q;
  logic [ITEM_W-1:0] ct_side;
  logic [DIV_DW-1:0] cp_q;
  logic [DIV_DW-1:0] cf_q;
  lrp_item_t         ci;
  lrp_ctx_t          ci_ctx;

  // Spin step divider
  logic              ds_v;
  logic [DIV_NW-1:0] ds_q;
  logic [CTX_W+7:0]  ds_side;
  lrp_ctx_t          ds_ctx;
  logic [7:0]        ds_k;

  logic        s1_v_r;
  lrp_ctx_t    s1_ctx_r;
  logic [15:0] s1_off_r;
  logic [23:0] s1_prod;

  logic              do_v;
  logic [DIV_DW-1:0] do_q;
  logic [CTX_W-1:0]  do_side;
  lrp_ctx_t          do_ctx;

  logic        s2_v_r;
  lrp_ctx_t    s2_ctx_r;
  logic [31:0] s2_x_r;

  logic              dx_v;
  logic [DIV_NW-1:0] dx_q;
  logic [DIV_DW-1:0] dx_rem;
  logic [CTX_W-1:0]  dx_side;
  lrp_ctx_t          dx_ctx;

  logic             s3_v_r;
  lrp_ctx_t         s3_ctx_r;
  logic [2:0][23:0] s3_num_r;
  logic [2:0][23:0] s3_num_nxt;
  logic [15:0]      php;

  logic              dc_v;
  logic [CTX_W-1:0]  dc_side;
  lrp_ctx_t          dc_ctx;
  logic [2:0][23:0]  dc_q;

  logic        s4_v_r;
  logic [23:0] s4_color_r;
  logic [23:0] s4_color_nxt;

  logic        out_v_r;
  logic [23:0] out_color_r;

  // Map a wheel position to a rainbow color
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] w3;
    w = CH_MAX - pos;
    if (w < WHEEL_SEG1) begin
      w3 = 8'(w * 2'd3);
      return {CH_MAX - w3, 8'd0, w3};
    end else if (w < WHEEL_SEG2) begin
      w3 = 8'((w - WHEEL_SEG1) * 2'd3);
      return {8'd0, w3, CH_MAX - w3};
    end else begin
      w3 = 8'((w - WHEEL_SEG2) * 2'd3);
      return {w3, CH_MAX - w3, 8'd0};
    end
  endfunction

  // Advance the whole pipeline unless the output is stalled
  assign en    = !out_v_r || out_if.ready;
  assign q_pop = en && !q_empty;

  lrp_cdiv #(.NW(DIV_NW), .DIVISOR(TIME_DIVISOR), .SW(ITEM_W)) u_cdiv_t (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(q_pop),
    .num_i(q_item.time_ms), .side_i(q_item),
    .v_o(ct_v), .quo_o(ct_q), .side_o(ct_side)
  );

  lrp_cdiv #(.NW(DIV_DW), .DIVISOR(TIME_DIVISOR), .SW(1)) u_cdiv_p (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(q_pop),
    .num_i(q_item.period), .side_i(1'b0),
    .v_o(), .quo_o(cp_q), .side_o()
  );

  lrp_cdiv #(.NW(DIV_DW), .DIVISOR(PCT_FULL), .SW(1)) u_cdiv_f (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(q_pop),
    .num_i(q_item.fill_num), .side_i(1'b0),
    .v_o(), .quo_o(cf_q), .side_o()
  );

  // Clamp period, progress fill test
  assign ci = lrp_item_t'(ct_side);

  always_comb begin
    ci_ctx.pattern = ci.pattern;
    ci_ctx.color   = ci.color;
    ci_ctx.pix     = ci.pix;
    ci_ctx.t       = ct_q;
    ci_ctx.p       = (cp_q == 16'd0) ? 16'd1 : cp_q;
    ci_ctx.infill  = ({8'd0, ci.k} < cf_q);
  end

  lrp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(CTX_W + 8)) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(ct_v),
    .num_i({16'd0, ci.period}), .den_i({8'd0, ci.len}), .side_i({ci_ctx, ci.k}),
    .v_o(ds_v), .quo_o(ds_q), .rem_o(), .side_o(ds_side)
  );

  // Stage 1: spin offset
  assign ds_ctx  = lrp_ctx_t'(ds_side[CTX_W+7:8]);
  assign ds_k    = ds_side[7:0];
  assign s1_prod = ds_q[15:0] * ds_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= ds_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx_r <= ds_ctx;
      s1_off_r <= s1_prod[15:0];
    end
  end

  lrp_cdiv #(.NW(DIV_DW), .DIVISOR(TIME_DIVISOR), .SW(CTX_W)) u_cdiv_o (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(s1_v_r),
    .num_i(s1_off_r), .side_i(s1_ctx_r),
    .v_o(do_v), .quo_o(do_q), .side_o(do_side)
  );

  // Stage 2: phase-shifted time for spin
  assign do_ctx = lrp_ctx_t'(do_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= do_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx_r <= do_ctx;
      s2_x_r   <= do_ctx.t + ((do_ctx.pattern == PAT_SPIN) ? {16'd0, do_q} : 32'd0);
    end
  end

  lrp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(CTX_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(s2_v_r),
    .num_i(s2_x_r), .den_i(s2_ctx_r.p), .side_i(s2_ctx_r),
    .v_o(dx_v), .quo_o(dx_q), .rem_o(dx_rem), .side_o(dx_side)
  );

  // Stage 3: fold the phase on odd periods, scale each channel span
  assign dx_ctx = lrp_ctx_t'(dx_side);
  assign php    = dx_q[0] ? (dx_ctx.p - dx_rem) : dx_rem;

  always_comb begin
    logic [7:0] c;
    logic [7:0] f;
    for (int ch = 0; ch < 3; ch++) begin
      c = dx_ctx.color[ch*8 +: 8];
      f = (dx_ctx.pattern == PAT_PROGRESS) ? {2'b00, c[7:2]} : 8'd0;
      s3_num_nxt[ch] = php * (c - f);
    end
    if (dx_ctx.pattern == PAT_RAINBOW) begin
      s3_num_nxt[0] = dx_rem * CH_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= dx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx_r <= dx_ctx;
      s3_num_r <= s3_num_nxt;
    end
  end

  lrp_div #(.NW(CH_NW), .DW(DIV_DW), .SW(CTX_W)) u_div_c0 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(s3_v_r),
    .num_i(s3_num_r[0]), .den_i(s3_ctx_r.p), .side_i(s3_ctx_r),
    .v_o(dc_v), .quo_o(dc_q[0]), .rem_o(), .side_o(dc_side)
  );

  lrp_div #(.NW(CH_NW), .DW(DIV_DW), .SW(1)) u_div_c1 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(s3_v_r),
    .num_i(s3_num_r[1]), .den_i(s3_ctx_r.p), .side_i(1'b0),
    .v_o(), .quo_o(dc_q[1]), .rem_o(), .side_o()
  );

  lrp_div #(.NW(CH_NW), .DW(DIV_DW), .SW(1)) u_div_c2 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(s3_v_r),
    .num_i(s3_num_r[2]), .den_i(s3_ctx_r.p), .side_i(1'b0),
    .v_o(), .quo_o(dc_q[2]), .rem_o(), .side_o()
  );

  // Stage 4: add the floor color and pick by pattern
  assign dc_ctx = lrp_ctx_t'(dc_side);

  always_comb begin
    logic [23:0] pulse_c;
    logic [23:0] off_c;
    logic [7:0]  c;
    logic [7:0]  f;
    logic [8:0]  sum;
    for (int ch = 0; ch < 3; ch++) begin
      c   = dc_ctx.color[ch*8 +: 8];
      f   = (dc_ctx.pattern == PAT_PROGRESS) ? {2'b00, c[7:2]} : 8'd0;
      sum = dc_q[ch][8:0] + {1'b0, f};
      off_c[ch*8 +: 8]   = {2'b00, c[7:2]};
      pulse_c[ch*8 +: 8] = (sum > {1'b0, CH_MAX}) ? CH_MAX : sum[7:0];
    end
    case (dc_ctx.pattern)
      PAT_SOLID:    s4_color_nxt = dc_ctx.color;
      PAT_PULSE:    s4_color_nxt = pulse_c;
      PAT_PROGRESS: s4_color_nxt = dc_ctx.infill ? pulse_c : off_c;
      PAT_SPIN:     s4_color_nxt = pulse_c;
      PAT_RAINBOW:  s4_color_nxt = wheel(dc_ctx.pix + dc_q[0][7:0]);
      default:      s4_color_nxt = 24'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= dc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_color_r <= s4_color_nxt;
    end
  end

  // Output register: gamma per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_color_r <= {GAMMA_LUT[s4_color_r[23:16]], GAMMA_LUT[s4_color_r[15:8]],
                      GAMMA_LUT[s4_color_r[7:0]]};
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.pixel_color = out_color_r;

endmodule

[rtl/led_ring_pattern_pixel_color_unit.sv]
// Top level of the LED ring pixel color unit.
// Depends on lrp_pkg, lrp_if, lrp_front, lrp_fifo and lrp_back.
//
// Usage:
//   in_if  : valid/ready channel, one pixel request per transfer (pattern,
//            ring color, period, progress, pixel index, ring start/length,
//            time in ms). A request moves when valid and ready are high.
//   out_if : valid/ready channel, one gamma-corrected RGB color per request,
//            in request order.
//   Path: from request to out_if.valid, the bit-per-stage pipelined dividers
//            (32 + 32 + 24 stages) make up most of the pipeline, with two
//            constant dividers in series, the front stage, the queue and the
//            per-stage registers making up the rest.
//   Throughput: one pixel per cycle while out_if is not stalled; every divider
//            takes a new operand each cycle in which the pipeline advances.
//   Reset: rst_n low for one clock empties the pipeline and queue; in_if.ready
//            is high in the first cycle after reset.
//   Stall: when out_if.ready is low with a result waiting, the back end holds;
//            the front stage and the two-entry queue keep accepting until full.
module led_ring_pattern_pixel_color_unit #(
  parameter int TIME_DIVISOR = lrp_pkg::LRP_TIME_DIVISOR,
  parameter int QUEUE_DEPTH  = lrp_pkg::LRP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  lrp_in_if.sink    in_if,
  lrp_out_if.source out_if
);
  import lrp_pkg::*;

  lrp_item_t f_item;
  lrp_item_t q_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  lrp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if),
    .q_full(q_full), .q_push(q_push), .q_item(f_item)
  );

  lrp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(f_item),
    .pop(q_pop), .dout(q_item), .full(q_full), .empty(q_empty)
  );

  lrp_back #(.TIME_DIVISOR(TIME_DIVISOR)) u_back (
    .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_empty(q_empty),
    .q_pop(q_pop), .out_if(out_if)
  );

endmodule

[rtl/lrp_checker.sv]
// Port-level checks for the LED ring pixel color unit, bound to the top.
// Depends on led_ring_pattern_pixel_color_unit.
module lrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_pixel_color
);

  // Hold a waiting result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_color))
    else $error("result changed while stalled");

  // Drop everything on reset: no result is shown just after it
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result shown right after reset");

  // Front end is free right after reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind led_ring_pattern_pixel_color_unit lrp_checker u_lrp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_pixel_color(out_if.pixel_color)
);

[test/lrp_test_if.sv]
// Testbench-side note: channel interfaces come from rtl/lrp_if.sv.
// This file holds the helper package with the request type used by the testbench.
// Depends on lrp_pkg.
`timescale 1ns / 1ps
package lrp_test_pkg;
  import lrp_pkg::*;

  typedef struct packed {
    logic [2:0]  pattern;
    logic [23:0] ring_color;
    logic [15:0] period_ms;
    logic [7:0]  progress_percent;
    logic [7:0]  pixel_index;
    logic [7:0]  ring_start;
    logic [7:0]  ring_length;
    logic [31:0] time_ms;
  } pixel_req_t;
endpackage

[test/led_ring_pattern_pixel_color_unit_test.sv]
// Testbench for the LED ring pixel color unit: random and directed pixel
// requests, colors predicted in the bench and checked in order.
// Depends on lrp_pkg, lrp_test_pkg, lrp_if and the top level.
`timescale 1ns / 1ps
module led_ring_pattern_pixel_color_unit_test;
  import lrp_pkg::*;
  import lrp_test_pkg::*;

  localparam int TDIV = LRP_TIME_DIVISOR;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lrp_in_if  in_if();
  lrp_out_if out_if();

  led_ring_pattern_pixel_color_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source)
  );

  pixel_req_t  pending_reqs[$];
  logic [23:0] expected_colors[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          hold_until_drained = 1'b0;
  bit          stim_done = 1'b0;
  int          stall_phase = 0;

  // Gamma: largest g with g*g*255^3 <= v^5
  function automatic logic [7:0] gamma_of(logic [7:0] v);
    longint unsigned v5;
    longint unsigned t;
    logic [7:0]      g;
    v5 = longint'(v) * v * v * v * v;
    g  = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      t = longint'(g | (8'd1 << b));
      if (t * t * 64'd16581375 <= v5) g = 8'(t);
    end
    return g;
  endfunction

  function automatic logic [31:0] condensed_period(logic [15:0] period);
    logic [31:0] p;
    p = period / TDIV;
    return (p == 0) ? 32'd1 : p;
  endfunction

  // Triangle ramp from off to color
  function automatic logic [23:0] ramp_color(logic [23:0] color, logic [23:0] off,
                                             logic [15:0] period, logic [15:0] offset,
                                             logic [31:0] t_ms);
    logic [31:0] p, x, ph, d, v;
    logic [7:0]  c, f;
    logic [23:0] res;
    p   = condensed_period(period);
    x   = t_ms / TDIV + offset / TDIV;
    ph  = x % p;
    res = '0;
    if ((x / p) & 1) ph = p - ph;
    for (int sh = 16; sh >= 0; sh -= 8) begin
      c = color[sh +: 8];
      f = off[sh +: 8];
      d = (c >= f) ? c - f : 0;
      v = 32'((64'(ph) * d) / p) + f;
      if (v > 255) v = 255;
      res[sh +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] wheel_color(logic [7:0] pos);
    logic [31:0] w;
    w = 255 - pos;
    if (w < 85) return {8'(255 - w * 3), 8'd0, 8'(w * 3)};
    if (w < 170) begin
      w -= 85;
      return {8'd0, 8'(w * 3), 8'(255 - w * 3)};
    end
    w -= 170;
    return {8'(w * 3), 8'(255 - w * 3), 8'd0};
  endfunction

  function automatic logic [23:0] pixel_color_of(pixel_req_t r);
    logic [7:0]  k;
    logic [31:0] fill, len, step, p, pos;
    logic [23:0] off, c;
    k = r.pixel_index - r.ring_start;
    case (r.pattern)
      PAT_SOLID:   c = r.ring_color;
      PAT_PULSE:   c = ramp_color(r.ring_color, 24'd0, r.period_ms, 16'd0, r.time_ms);
      PAT_PROGRESS: begin
        fill = r.ring_length * r.progress_percent / 100;
        off  = {r.ring_color[23:16] >> 2, r.ring_color[15:8] >> 2, r.ring_color[7:0] >> 2};
        c = (k < fill) ? ramp_color(r.ring_color, off, r.period_ms, 16'd0, r.time_ms) : off;
      end
      PAT_SPIN: begin
        len  = (r.ring_length == 0) ? 1 : r.ring_length;
        step = r.period_ms / len;
        c = ramp_color(r.ring_color, 24'd0, r.period_ms, 16'(step * k), r.time_ms);
      end
      PAT_RAINBOW: begin
        p   = condensed_period(r.period_ms);
        pos = 255 * ((r.time_ms / TDIV) % p) / p;
        c   = wheel_color(8'(r.pixel_index + pos));
      end
      default:     c = 24'd0;
    endcase
    return {gamma_of(c[23:16]), gamma_of(c[15:8]), gamma_of(c[7:0])};
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t r;
    r = '0;
    r.pattern = (($urandom % 8) < 7) ? 3'($urandom_range(0, 4)) : 3'($urandom);
    r.ring_color = 24'($urandom);
    case ($urandom % 4)
      0: r.period_ms = 16'($urandom_range(0, 40));
      1: r.period_ms = 16'($urandom_range(0, 2000));
      default: r.period_ms = 16'($urandom);
    endcase
    r.progress_percent = (($urandom % 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
    r.ring_start = 8'($urandom);
    r.ring_length = ($urandom % 16 == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r.pixel_index = ($urandom % 4 == 0) ? 8'($urandom)
                  : 8'(r.ring_start + $urandom_range(0, r.ring_length));
    r.time_ms = ($urandom % 2) ? $urandom : $urandom_range(0, 5000);
    return r;
  endfunction

  initial forever #4 clk = ~clk;

  // Reset at start, then release
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Fill the request queue: directed corners, random traffic, a full drain, then more random traffic
  initial begin
    pixel_req_t r;
    for (int i = 0; i < 8; i++) begin
      r = '0;
      r.pattern = 3'(i);
      r.ring_color = 24'hFFFFFF;
      r.period_ms = (i % 2) ? 16'hFFFF : 16'd0;
      r.progress_percent = 8'd100;
      r.pixel_index = 8'd3;
      r.ring_length = 8'd10;
      r.time_ms = (i % 2) ? 32'hFFFFFFFF : 32'd123;
      pending_reqs.push_back(r);
    end
    r = '0; r.pattern = PAT_SPIN; r.ring_color = 24'h80FF01; r.period_ms = 16'd5;
    r.ring_length = 8'd0; r.pixel_index = 8'd7; pending_reqs.push_back(r);
    r = '0; r.pattern = PAT_PROGRESS; r.ring_color = 24'hFF8040; r.ring_length = 8'd0;
    r.progress_percent = 8'd255; pending_reqs.push_back(r);
    r = '0; r.pattern = PAT_PROGRESS; r.ring_color = 24'hFF8040; r.ring_length = 8'd255;
    r.progress_percent = 8'd255; r.pixel_index = 8'd5; r.ring_start = 8'd10;
    r.period_ms = 16'd800; r.time_ms = 32'd1000; pending_reqs.push_back(r);
    r = '0; r.pattern = PAT_PULSE; r.ring_color = 24'h0000FF; r.period_ms = 16'd80;
    r.time_ms = 32'd960; pending_reqs.push_back(r);
    r = '0; r.pattern = PAT_RAINBOW; r.pixel_index = 8'd255; r.period_ms = 16'd8;
    r.time_ms = 32'hFFFFFFFF; pending_reqs.push_back(r);
    for (int i = 0; i < 950; i++) pending_reqs.push_back(random_req());
    // Drain fully once before the rest
    wait (pending_reqs.size() == 0 && !in_if.valid);
    hold_until_drained = 1'b1;
    wait (expected_colors.size() == 0);
    @(posedge clk);
    hold_until_drained = 1'b0;
    for (int i = 0; i < 950; i++) pending_reqs.push_back(random_req());
    stim_done = 1'b1;
  end

  // Driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pattern <= '0; in_if.ring_color <= '0; in_if.period_ms <= '0;
      in_if.progress_percent <= '0; in_if.pixel_index <= '0;
      in_if.ring_start <= '0; in_if.ring_length <= '0; in_if.time_ms <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) expected_colors.push_back(pixel_color_of({in_if.pattern,
          in_if.ring_color, in_if.period_ms, in_if.progress_percent, in_if.pixel_index,
          in_if.ring_start, in_if.ring_length, in_if.time_ms}));
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (gap_left == 0 && burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left == 0 && burst_left > 0 && !hold_until_drained
          && pending_reqs.size() > 0) begin
        {in_if.pattern, in_if.ring_color, in_if.period_ms, in_if.progress_percent,
         in_if.pixel_index, in_if.ring_start, in_if.ring_length, in_if.time_ms}
          <= pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        burst_left <= burst_left - 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_colors.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected color %h", out_if.pixel_color);
        end else if (out_if.pixel_color !== expected_colors[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("color mismatch: expected %h actual %h", expected_colors[0],
                     out_if.pixel_color);
          void'(expected_colors.pop_front());
        end else begin
          void'(expected_colors.pop_front());
        end
      end
      stall_phase <= (stall_phase + 1) % 600;
      out_if.ready <= (stall_phase < 300) ? 1'b1 : ($urandom % 4 != 0);
    end
  end

  // End of run
  initial begin
    wait (stim_done && pending_reqs.size() == 0 && !in_if.valid);
    wait (expected_colors.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_colors.size() == 0)
      $display("[led_ring_pattern_pixel_color_unit] OK");
    else
      $display("[led_ring_pattern_pixel_color_unit] ERROR");
    $finish;
  end

  // Timeout
  initial begin
    #(8 * 200000);
    $display("[led_ring_pattern_pixel_color_unit] ERROR");
    $finish;
  end
endmodule

[led_ring_pattern_pixel_color_unit.f]
rtl/lrp_pkg.sv
rtl/lrp_if.sv
rtl/lrp_front.sv
rtl/lrp_fifo.sv
rtl/lrp_div.sv
rtl/lrp_back.sv
rtl/led_ring_pattern_pixel_color_unit.sv
rtl/lrp_checker.sv
test/lrp_test_if.sv
test/led_ring_pattern_pixel_color_unit_test.sv
